// ----- hw/rtl/parse_date_time_to_epoch_defines.svh -----
// Assertion macros shared by the timestamp parser RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef PARSE_DATE_TIME_TO_EPOCH_DEFINES_SVH
`define PARSE_DATE_TIME_TO_EPOCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDTE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdte assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PDTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdte assertion failed");

`endif

// ----- hw/rtl/pdte_pkg.sv -----
// Shared types for the timestamp parser.
// No dependencies; the scanner, the calculator and the top level import this package.
package pdte_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_MALFORMED = 2'd1,
    STATUS_RANGE     = 2'd2
  } status_t;

  // Field values of one complete text, handed from the scanner to the calculator.
  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic        malformed;
  } fields_t;

endpackage

// ----- hw/rtl/pdte_if.sv -----
// Valid/ready channel interfaces for the timestamp parser.
// Character input words and result output words; no dependencies.
interface pdte_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_last;

  modport source (output valid, output ch, output is_last, input ready);
  modport sink (input valid, input ch, input is_last, output ready);
endinterface

interface pdte_result_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [38:0] epoch_seconds;

  modport source (output valid, output status, output epoch_seconds, input ready);
  modport sink (input valid, input status, input epoch_seconds, output ready);
endinterface

// ----- hw/rtl/parse_date_time_to_epoch.sv -----
// Timestamp text parser: "YYYY-MM-DD", "YYYY-MM-DD HH:MM" or "YYYY-MM-DD HH:MM:SS"
// to signed seconds since 1970-01-01 00:00:00 UTC. Depends on pdte_pkg, pdte_if,
// pdte_scan, pdte_calc and parse_date_time_to_epoch_defines.svh.
//
// The chars channel takes one character word per cycle while chars.ready is high; is_last
// marks the final character of a text. Every accepted character updates the scanner's
// counters at once, so a text streams in at one word per cycle with no gaps unless chars.ready drops.
// The result channel gives one word per text: a status (ok, malformed, out of
// range) and epoch_seconds, which is zero unless the status is ok.
// The final character's fields pass through the f1, s2, s3 and output registers in
// that order before the result word turns valid. Throughput: one character per cycle,
// and one text per cycle even for one-character texts, set by the four-stage
// calculator pipeline, while the receiver does not stall.
// When the receiver stalls, finished results hold in the pipeline; characters keep
// flowing while any stage is empty, and chars.ready drops only once all four stages
// hold results.
// A synchronous reset clears the scanner and empties the pipeline; the block is
// ready for a new text in the cycle after reset.
`include "parse_date_time_to_epoch_defines.svh"

module parse_date_time_to_epoch import pdte_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  pdte_char_if.sink     chars,
  pdte_result_if.source result
);

  logic    accept;
  logic    calc_ready;
  fields_t fields;

  // The calculator's first stage must have room, since the word may be the last one.
  assign chars.ready = calc_ready;
  assign accept      = chars.valid && chars.ready;

  pdte_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .ch      (chars.ch),
    .is_last (chars.is_last),
    .fields  (fields)
  );

  pdte_calc u_calc (
    .clk    (clk),
    .rst    (rst),
    .load   (accept && chars.is_last),
    .fields (fields),
    .ready  (calc_ready),
    .result (result)
  );

  // A failed text never carries seconds.
  `PDTE_ASSERT_SAME(a_zero_on_error, result.valid && (result.status != STATUS_OK), result.epoch_seconds == 39'sd0)

  // A valid date lies within years 1 to 9999.
  `PDTE_ASSERT_SAME(a_ok_in_range, result.valid && (result.status == STATUS_OK), (result.epoch_seconds >= -39'sd62135596800) && (result.epoch_seconds <= 39'sd253402300799))

  // Right after reset the pipeline is empty and characters are taken.
  `PDTE_ASSERT_SAME(a_ready_after_reset, $past(rst), chars.ready && !result.valid)

endmodule

// ----- hw/rtl/pdte_scan.sv -----
// Character scanner: position counter, digit accumulators and format check.
// Depends on pdte_pkg.
module pdte_scan import pdte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       is_last,
  output fields_t    fields
);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [4:0] LAST_POS = 5'd19;
  localparam logic [4:0] LEN_DATE = 5'd10;
  localparam logic [4:0] LEN_HM   = 5'd16;
  localparam logic [4:0] LEN_HMS  = 5'd19;

  logic [4:0]  pos, pos_next, len;
  logic [13:0] year, year_next;
  logic [6:0]  month, month_next, day, day_next;
  logic [6:0]  hour, hour_next, minute, minute_next, second, second_next;
  logic        ferr, ferr_next, bad, is_digit;
  logic [3:0]  digit;

  function automatic logic [6:0] mac7(input logic [6:0] acc, input logic [3:0] d);
    logic [6:0] t;
    t = acc * 7'd10;
    return t + {3'b000, d};
  endfunction

  function automatic logic [13:0] mac14(input logic [13:0] acc, input logic [3:0] d);
    logic [13:0] t;
    t = acc * 14'd10;
    return t + {10'd0, d};
  endfunction

  always_comb begin
    is_digit    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    digit       = ch[3:0];
    year_next   = year;
    month_next  = month;
    day_next    = day;
    hour_next   = hour;
    minute_next = minute;
    second_next = second;
    bad         = 1'b0;
    case (pos)
      5'd0, 5'd1, 5'd2, 5'd3: begin
        if (is_digit) year_next = mac14(year, digit);
        else bad = 1'b1;
      end
      5'd5, 5'd6: begin
        if (is_digit) month_next = mac7(month, digit);
        else bad = 1'b1;
      end
      5'd8, 5'd9: begin
        if (is_digit) day_next = mac7(day, digit);
        else bad = 1'b1;
      end
      5'd11, 5'd12: begin
        if (is_digit) hour_next = mac7(hour, digit);
        else bad = 1'b1;
      end
      5'd14, 5'd15: begin
        if (is_digit) minute_next = mac7(minute, digit);
        else bad = 1'b1;
      end
      5'd17, 5'd18: begin
        if (is_digit) second_next = mac7(second, digit);
        else bad = 1'b1;
      end
      5'd4, 5'd7:   bad = (ch != CH_DASH);
      5'd10:        bad = (ch != CH_SPACE);
      5'd13, 5'd16: bad = (ch != CH_COLON);
      default:      bad = 1'b1;
    endcase
    ferr_next = ferr | bad;
    len       = pos + 5'd1;
    pos_next  = (pos < LAST_POS) ? len : LAST_POS;

    fields.year      = year_next;
    fields.month     = month_next;
    fields.day       = day_next;
    fields.hour      = hour_next;
    fields.minute    = minute_next;
    fields.second    = second_next;
    fields.malformed = ferr_next || (pos >= LAST_POS) ||
                       !((len == LEN_DATE) || (len == LEN_HM) || (len == LEN_HMS));
  end

  // A final character hands its fields on and clears the scanner for the next text.
  always_ff @(posedge clk) begin
    if (rst || (accept && is_last)) begin
      pos    <= '0;
      year   <= '0;
      month  <= '0;
      day    <= '0;
      hour   <= '0;
      minute <= '0;
      second <= '0;
      ferr   <= 1'b0;
    end else if (accept) begin
      pos    <= pos_next;
      year   <= year_next;
      month  <= month_next;
      day    <= day_next;
      hour   <= hour_next;
      minute <= minute_next;
      second <= second_next;
      ferr   <= ferr_next;
    end
  end

endmodule

// ----- hw/rtl/pdte_calc.sv -----
// Four-stage calculator: range checks, calendar day count and seconds since 1970.
// Depends on pdte_pkg and pdte_if.
module pdte_calc import pdte_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  fields_t              fields,
  output logic                 ready,
  pdte_result_if.source        result
);

  // floor(x / 100) equals (x * RECIP_100) >> RECIP_SHIFT for every 14-bit x.
  localparam logic [27:0] RECIP_100   = 28'd10486;
  localparam int          RECIP_SHIFT = 20;
  localparam logic signed [23:0] DAYS_TO_EPOCH = 24'sd719468;

  typedef struct packed {
    logic [13:0] year;
    logic [13:0] yy;
    logic [7:0]  qy;
    logic [7:0]  qyy;
    logic [3:0]  month;
    logic [6:0]  day;
    logic [8:0]  doy;
    logic [16:0] sod;
    logic        malformed;
    logic        range_err;
  } s2_t;

  typedef struct packed {
    logic signed [23:0] days;
    logic [16:0]        sod;
    status_t            status;
  } s3_t;

  // Days from March 1 to the first of each month.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    case (m)
      4'd1:    return 9'd306;
      4'd2:    return 9'd337;
      4'd4:    return 9'd31;
      4'd5:    return 9'd61;
      4'd6:    return 9'd92;
      4'd7:    return 9'd122;
      4'd8:    return 9'd153;
      4'd9:    return 9'd184;
      4'd10:   return 9'd214;
      4'd11:   return 9'd245;
      4'd12:   return 9'd275;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd2:                      return leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
      default:                   return 5'd31;
    endcase
  endfunction

  logic    v1, v2, v3, vo;
  logic    r1, r2, r3, ro;
  fields_t f1;
  s2_t     s2, s2_next;
  s3_t     s3, s3_next;

  logic [27:0] prod_y, prod_yy;
  logic [13:0] qy100;
  logic        leap, day_err;
  logic [22:0] day_sum;
  logic signed [38:0] days_w, epoch;
  logic [1:0]  status_q;
  logic signed [38:0] epoch_q;

  // Stage 1: divide-by-100 products, simple range checks, day of year, time of day.
  always_comb begin
    s2_next.year  = f1.year;
    s2_next.yy    = (f1.month <= 7'd2) ? f1.year - 14'd1 : f1.year;
    prod_y        = 28'(f1.year) * RECIP_100;
    prod_yy       = 28'(s2_next.yy) * RECIP_100;
    s2_next.qy    = prod_y[RECIP_SHIFT +: 8];
    s2_next.qyy   = prod_yy[RECIP_SHIFT +: 8];
    s2_next.month = f1.month[3:0];
    s2_next.day   = f1.day;
    s2_next.doy   = month_start(f1.month[3:0]) + 9'(f1.day) - 9'd1;
    s2_next.sod   = 17'(f1.hour) * 17'd3600 + 17'(f1.minute) * 17'd60 + 17'(f1.second);
    s2_next.malformed = f1.malformed;
    s2_next.range_err = (f1.year == 14'd0) || (f1.year > 14'd9999) ||
                        (f1.month == 7'd0) || (f1.month > 7'd12) ||
                        (f1.day == 7'd0) || (f1.hour > 7'd23) ||
                        (f1.minute > 7'd59) || (f1.second > 7'd59);
  end

  // Stage 2: leap rule, month length, day count relative to 1970-01-01.
  always_comb begin
    qy100   = 14'(s2.qy) * 14'd100;
    leap    = (s2.year[1:0] == 2'b00) && ((s2.year != qy100) || (s2.qy[1:0] == 2'b00));
    day_err = s2.day > 7'(month_len(s2.month, leap));
    day_sum = 23'(s2.yy) * 23'd365 + 23'(s2.yy >> 2) + 23'(s2.qyy >> 2) -
              23'(s2.qyy) + 23'(s2.doy);
    s3_next.days = $signed({1'b0, day_sum}) - DAYS_TO_EPOCH;
    s3_next.sod  = s2.sod;
    if (s2.malformed) s3_next.status = STATUS_MALFORMED;
    else if (s2.range_err || day_err) s3_next.status = STATUS_RANGE;
    else s3_next.status = STATUS_OK;
  end

  // Stage 3: scale days to seconds and add the time of day.
  always_comb begin
    days_w = 39'(s3.days);
    epoch  = days_w * 39'sd86400 + 39'(s3.sod);
    if (s3.status != STATUS_OK) epoch = '0;
  end

  // Each stage moves on when the next one is empty or moving, so bubbles close up.
  assign ro    = !vo || result.ready;
  assign r3    = !v3 || ro;
  assign r2    = !v2 || r3;
  assign r1    = !v1 || r2;
  assign ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (r1) v1 <= load;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (ro) vo <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && load) f1 <= fields;
    if (r2 && v1) s2 <= s2_next;
    if (r3 && v2) s3 <= s3_next;
    if (ro && v3) begin
      status_q <= s3.status;
      epoch_q  <= epoch;
    end
  end

  assign result.valid         = vo;
  assign result.status        = status_q;
  assign result.epoch_seconds = epoch_q;

endmodule
